// File: src/threshold_union_find_max_group_defines.svh
// assertion macros for the threshold union-find block
// used by the port checker, no other dependencies
`ifndef THRESHOLD_UNION_FIND_MAX_GROUP_DEFINES_SVH
`define THRESHOLD_UNION_FIND_MAX_GROUP_DEFINES_SVH

// same-cycle implication, masked during reset
`define TUFMG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tufmg check failed");

// next-cycle implication, masked during reset
`define TUFMG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tufmg check failed");

// next-cycle implication that also covers the reset cycles
`define TUFMG_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tufmg check failed");

`endif

// File: src/tufmg_pkg.sv
// shared constants, codes and memory request types for the union-find block
// no dependencies
`timescale 1ns / 1ps

package tufmg_pkg;

  // sizes of the node and tag stores
  localparam int MAX_NODES = 1024;
  localparam int MAX_TAGS  = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int TAG_W     = $clog2(MAX_TAGS);
  localparam int FILL_W    = $clog2(MAX_TAGS + 1);

  // field and register widths
  localparam int OP_W      = 2;
  localparam int IN_NODE_W = 10;
  localparam int WEIGHT_W  = 53;
  localparam int THR_W     = 62;
  localparam int NCNT_W    = 11;
  localparam int CNT_W     = 11;
  localparam int RANK_W    = 4;
  localparam int CFG_IDX_W = 1;

  localparam int RANK_MAX  = 15;
  localparam int COUNT_MAX = 2047;
  // tag distance is scaled by four before the threshold compare
  localparam int TAG_SHIFT = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_EDGE = 2'd0;
  localparam logic [OP_W-1:0] OP_TAG  = 2'd1;
  localparam logic [OP_W-1:0] OP_EVAL = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd1;

  // write and read controls from the sequencer to the stores
  typedef struct packed {
    logic                parent_we;
    logic [NODE_W-1:0]   parent_waddr;
    logic [NODE_W-1:0]   parent_wdata;
    logic                rank_we;
    logic [NODE_W-1:0]   rank_waddr;
    logic [RANK_W-1:0]   rank_wdata;
    logic [NODE_W-1:0]   node_raddr;
    logic                tag_we;
    logic [TAG_W-1:0]    tag_waddr;
    logic [NODE_W-1:0]   tag_wdata;
    logic [TAG_W-1:0]    tag_raddr;
    logic                tally_we;
    logic [NODE_W-1:0]   tally_waddr;
    logic [FILL_W-1:0]   tally_wdata;
    logic [NODE_W-1:0]   tally_raddr;
  } mem_req_t;

  // registered read data from the stores
  typedef struct packed {
    logic [NODE_W-1:0]   parent_rdata;
    logic [RANK_W-1:0]   rank_rdata;
    logic [NODE_W-1:0]   tag_rdata;
    logic [FILL_W-1:0]   tally_rdata;
  } mem_rsp_t;

endpackage

// File: src/tufmg_if.sv
// valid/ready channel interfaces: input request, result, configuration write
// depends on tufmg_pkg
`timescale 1ns / 1ps

interface tufmg_in_if;
  logic                               valid;
  logic                               ready;
  logic [tufmg_pkg::OP_W-1:0]         operation;
  logic [tufmg_pkg::IN_NODE_W-1:0]    first_node;
  logic [tufmg_pkg::IN_NODE_W-1:0]    second_node;
  logic [tufmg_pkg::WEIGHT_W-1:0]     weight;

  modport source (output valid, operation, first_node, second_node, weight, input ready);
  modport sink (input valid, operation, first_node, second_node, weight, output ready);
endinterface

interface tufmg_out_if;
  logic                        valid;
  logic                        ready;
  logic [tufmg_pkg::CNT_W-1:0] largest_group_count;

  modport source (output valid, largest_group_count, input ready);
  modport sink (input valid, largest_group_count, output ready);
endinterface

interface tufmg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tufmg_pkg::CFG_IDX_W-1:0] index;
  logic [tufmg_pkg::THR_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/tufmg_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module tufmg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/tufmg_ctrl.sv
// sequencer: root walks, union by rank, tag list, tally pass and clearing sweep
// depends on tufmg_pkg and tufmg_if
`timescale 1ns / 1ps

module tufmg_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  tufmg_in_if.sink                      in_ch,
  input  logic [tufmg_pkg::THR_W-1:0]   threshold,
  input  logic [tufmg_pkg::NCNT_W-1:0]  node_count,
  input  logic                          out_free,
  output logic                          res_load,
  output logic [tufmg_pkg::CNT_W-1:0]   res_count,
  output tufmg_pkg::mem_req_t           mem_req,
  input  tufmg_pkg::mem_rsp_t           mem_rsp
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_FIND_A = 4'd3;
  localparam logic [3:0] S_FIND_B = 4'd4;
  localparam logic [3:0] S_TAG_RD = 4'd5;
  localparam logic [3:0] S_TAG_WT = 4'd6;
  localparam logic [3:0] S_FIND_T = 4'd7;
  localparam logic [3:0] S_TALLY  = 4'd8;
  localparam logic [3:0] S_RESULT = 4'd9;

  localparam logic [tufmg_pkg::NODE_W-1:0] LAST_NODE =
    tufmg_pkg::NODE_W'(tufmg_pkg::MAX_NODES - 1);

  logic [3:0]                        state, state_next;
  logic [tufmg_pkg::OP_W-1:0]        op, op_next;
  logic [tufmg_pkg::IN_NODE_W-1:0]   a_node, a_node_next;
  logic [tufmg_pkg::IN_NODE_W-1:0]   b_node, b_node_next;
  logic [tufmg_pkg::WEIGHT_W-1:0]    weight, weight_next;
  logic [tufmg_pkg::NODE_W-1:0]      cur, cur_next;
  logic [tufmg_pkg::NODE_W-1:0]      root_a, root_a_next;
  logic [tufmg_pkg::RANK_W-1:0]      rank_a, rank_a_next;
  logic [tufmg_pkg::FILL_W-1:0]      fill, fill_next;
  logic [tufmg_pkg::FILL_W-1:0]      tag_idx, tag_idx_next;
  logic [tufmg_pkg::NODE_W-1:0]      clr_idx, clr_idx_next;
  logic [tufmg_pkg::FILL_W-1:0]      best, best_next;

  logic [tufmg_pkg::NCNT_W-1:0]      n_eff;
  logic [tufmg_pkg::THR_W-1:0]       weight_ext;
  logic [tufmg_pkg::THR_W-1:0]       tag_dist;
  logic                              a_in_range;
  logic                              b_in_range;
  logic                              edge_keep;
  logic                              tag_keep;
  logic                              at_root;
  logic [tufmg_pkg::FILL_W-1:0]      tally_inc;
  logic [tufmg_pkg::FILL_W-1:0]      tag_idx_inc;

  // effective node count and threshold tests on the latched request
  always_comb begin
    if (node_count == '0) begin
      n_eff = tufmg_pkg::NCNT_W'(1);
    end else if (node_count > tufmg_pkg::NCNT_W'(tufmg_pkg::MAX_NODES)) begin
      n_eff = tufmg_pkg::NCNT_W'(tufmg_pkg::MAX_NODES);
    end else begin
      n_eff = node_count;
    end
  end

  assign weight_ext  = tufmg_pkg::THR_W'(weight);
  assign tag_dist    = weight_ext << tufmg_pkg::TAG_SHIFT;
  assign a_in_range  = tufmg_pkg::NCNT_W'(a_node) < n_eff;
  assign b_in_range  = tufmg_pkg::NCNT_W'(b_node) < n_eff;
  assign edge_keep   = (weight_ext <= threshold) && a_in_range && b_in_range;
  assign tag_keep    = (tag_dist <= threshold) && a_in_range &&
                       (fill < tufmg_pkg::FILL_W'(tufmg_pkg::MAX_TAGS));
  assign at_root     = mem_rsp.parent_rdata == cur;
  assign tally_inc   = mem_rsp.tally_rdata + tufmg_pkg::FILL_W'(1);
  assign tag_idx_inc = tag_idx + tufmg_pkg::FILL_W'(1);

  assign in_ch.ready = state == S_IDLE;
  assign res_load    = (state == S_RESULT) && out_free;
  assign res_count   = (best > tufmg_pkg::FILL_W'(tufmg_pkg::COUNT_MAX)) ?
                       tufmg_pkg::CNT_W'(tufmg_pkg::COUNT_MAX) :
                       tufmg_pkg::CNT_W'(best);

  // sequencer and store controls
  always_comb begin
    state_next   = state;
    op_next      = op;
    a_node_next  = a_node;
    b_node_next  = b_node;
    weight_next  = weight;
    cur_next     = cur;
    root_a_next  = root_a;
    rank_a_next  = rank_a;
    fill_next    = fill;
    tag_idx_next = tag_idx;
    clr_idx_next = clr_idx;
    best_next    = best;

    mem_req              = '0;
    mem_req.node_raddr   = cur;
    mem_req.tag_raddr    = tag_idx[tufmg_pkg::TAG_W-1:0];
    mem_req.tally_raddr  = cur;
    mem_req.tag_waddr    = fill[tufmg_pkg::TAG_W-1:0];
    mem_req.tag_wdata    = tufmg_pkg::NODE_W'(a_node);

    case (state)
      S_CLEAR: begin
        // restore every node to a singleton with zero rank and tally
        mem_req.parent_we    = 1'b1;
        mem_req.parent_waddr = clr_idx;
        mem_req.parent_wdata = clr_idx;
        mem_req.rank_we      = 1'b1;
        mem_req.rank_waddr   = clr_idx;
        mem_req.rank_wdata   = '0;
        mem_req.tally_we     = 1'b1;
        mem_req.tally_waddr  = clr_idx;
        mem_req.tally_wdata  = '0;
        fill_next            = '0;
        clr_idx_next         = clr_idx + tufmg_pkg::NODE_W'(1);
        if (clr_idx == LAST_NODE) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          op_next     = in_ch.operation;
          a_node_next = in_ch.first_node;
          b_node_next = in_ch.second_node;
          weight_next = in_ch.weight;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op)
          tufmg_pkg::OP_EDGE: begin
            if (edge_keep) begin
              mem_req.node_raddr = tufmg_pkg::NODE_W'(a_node);
              cur_next           = tufmg_pkg::NODE_W'(a_node);
              state_next         = S_FIND_A;
            end else begin
              state_next = S_IDLE;
            end
          end
          tufmg_pkg::OP_TAG: begin
            if (tag_keep) begin
              mem_req.tag_we = 1'b1;
              fill_next      = fill + tufmg_pkg::FILL_W'(1);
            end
            state_next = S_IDLE;
          end
          tufmg_pkg::OP_EVAL: begin
            best_next    = '0;
            tag_idx_next = '0;
            state_next   = (fill == '0) ? S_RESULT : S_TAG_RD;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_FIND_A: begin
        // one parent hop per cycle; on the root, start the second walk
        if (at_root) begin
          root_a_next        = cur;
          rank_a_next        = mem_rsp.rank_rdata;
          mem_req.node_raddr = tufmg_pkg::NODE_W'(b_node);
          cur_next           = tufmg_pkg::NODE_W'(b_node);
          state_next         = S_FIND_B;
        end else begin
          mem_req.node_raddr = mem_rsp.parent_rdata;
          cur_next           = mem_rsp.parent_rdata;
        end
      end
      S_FIND_B: begin
        if (at_root) begin
          // union by rank of the two roots
          if (root_a != cur) begin
            if (rank_a < mem_rsp.rank_rdata) begin
              mem_req.parent_we    = 1'b1;
              mem_req.parent_waddr = root_a;
              mem_req.parent_wdata = cur;
            end else begin
              mem_req.parent_we    = 1'b1;
              mem_req.parent_waddr = cur;
              mem_req.parent_wdata = root_a;
              if ((rank_a == mem_rsp.rank_rdata) &&
                  (rank_a < tufmg_pkg::RANK_W'(tufmg_pkg::RANK_MAX))) begin
                mem_req.rank_we    = 1'b1;
                mem_req.rank_waddr = root_a;
                mem_req.rank_wdata = rank_a + tufmg_pkg::RANK_W'(1);
              end
            end
          end
          state_next = S_IDLE;
        end else begin
          mem_req.node_raddr = mem_rsp.parent_rdata;
          cur_next           = mem_rsp.parent_rdata;
        end
      end
      S_TAG_RD: begin
        state_next = S_TAG_WT;
      end
      S_TAG_WT: begin
        mem_req.node_raddr = mem_rsp.tag_rdata;
        cur_next           = mem_rsp.tag_rdata;
        state_next         = S_FIND_T;
      end
      S_FIND_T: begin
        // tally read goes out at the root address when the walk ends
        if (at_root) begin
          state_next = S_TALLY;
        end else begin
          mem_req.node_raddr = mem_rsp.parent_rdata;
          cur_next           = mem_rsp.parent_rdata;
        end
      end
      S_TALLY: begin
        mem_req.tally_we    = 1'b1;
        mem_req.tally_waddr = cur;
        mem_req.tally_wdata = tally_inc;
        if (tally_inc > best) begin
          best_next = tally_inc;
        end
        tag_idx_next = tag_idx_inc;
        state_next   = (tag_idx_inc == fill) ? S_RESULT : S_TAG_RD;
      end
      S_RESULT: begin
        if (out_free) begin
          clr_idx_next = '0;
          state_next   = S_CLEAR;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      fill    <= '0;
      clr_idx <= '0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      clr_idx <= clr_idx_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op      <= op_next;
    a_node  <= a_node_next;
    b_node  <= b_node_next;
    weight  <= weight_next;
    cur     <= cur_next;
    root_a  <= root_a_next;
    rank_a  <= rank_a_next;
    tag_idx <= tag_idx_next;
    best    <= best_next;
  end

endmodule

// File: src/threshold_union_find_max_group.sv
// Threshold union-find with largest tagged group count.
// Channels: in_ch carries requests (operation, first_node, second_node, weight);
// out_ch carries one largest_group_count per evaluate request; cfg writes
// register 0 (threshold) or 1 (node_count) and is always ready.
// One request is worked at a time; in_ch.ready is high only while idle.
// Time from acceptance until ready again is set by the parent-link memory walk
// (one parent read per cycle through the single read port): a kept edge walks
// first_node and then second_node to their roots and links the two roots; a
// dropped edge or tag, a kept tag or an unused code goes back to idle after
// decode; an evaluate walks each kept tag node to its root and bumps that
// root's tally, then loads the result and runs the clearing pass.
// A result goes to the output register once the evaluate's tally pass ends.
// Reset: synchronous on rst; clears the registers to threshold 0 and
// node_count 1024 and runs the clearing pass over all 1024 nodes before the
// first request is taken.
// The result sits in an output register; while the receiver stalls, the next
// evaluate waits for it before its own result and clearing pass.
// depends on tufmg_pkg, tufmg_if, tufmg_ram and tufmg_ctrl
`timescale 1ns / 1ps

module threshold_union_find_max_group (
  input  logic         clk,
  input  logic         rst,
  tufmg_in_if.sink     in_ch,
  tufmg_out_if.source  out_ch,
  tufmg_cfg_if.sink    cfg
);

  logic [tufmg_pkg::THR_W-1:0]  threshold;
  logic [tufmg_pkg::NCNT_W-1:0] node_count;
  logic                         out_valid;
  logic [tufmg_pkg::CNT_W-1:0]  out_count;
  logic                         out_free;
  logic                         res_load;
  logic [tufmg_pkg::CNT_W-1:0]  res_count;
  tufmg_pkg::mem_req_t          mem_req;
  tufmg_pkg::mem_rsp_t          mem_rsp;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= '0;
      node_count <= tufmg_pkg::NCNT_W'(tufmg_pkg::MAX_NODES);
    end else if (cfg.valid) begin
      case (cfg.index)
        tufmg_pkg::CFG_THRESHOLD:  threshold  <= cfg.data;
        tufmg_pkg::CFG_NODE_COUNT: node_count <= cfg.data[tufmg_pkg::NCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // result output register
  assign out_free                   = !out_valid || out_ch.ready;
  assign out_ch.valid               = out_valid;
  assign out_ch.largest_group_count = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_count <= res_count;
    end
  end

  // sequencer
  tufmg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .threshold  (threshold),
    .node_count (node_count),
    .out_free   (out_free),
    .res_load   (res_load),
    .res_count  (res_count),
    .mem_req    (mem_req),
    .mem_rsp    (mem_rsp)
  );

  // parent links
  tufmg_ram #(
    .WIDTH (tufmg_pkg::NODE_W),
    .DEPTH (tufmg_pkg::MAX_NODES)
  ) u_parent (
    .clk   (clk),
    .we    (mem_req.parent_we),
    .waddr (mem_req.parent_waddr),
    .wdata (mem_req.parent_wdata),
    .raddr (mem_req.node_raddr),
    .rdata (mem_rsp.parent_rdata)
  );

  // group ranks, read at the same address as the parent links
  tufmg_ram #(
    .WIDTH (tufmg_pkg::RANK_W),
    .DEPTH (tufmg_pkg::MAX_NODES)
  ) u_rank (
    .clk   (clk),
    .we    (mem_req.rank_we),
    .waddr (mem_req.rank_waddr),
    .wdata (mem_req.rank_wdata),
    .raddr (mem_req.node_raddr),
    .rdata (mem_rsp.rank_rdata)
  );

  // kept tag nodes
  tufmg_ram #(
    .WIDTH (tufmg_pkg::NODE_W),
    .DEPTH (tufmg_pkg::MAX_TAGS)
  ) u_tag (
    .clk   (clk),
    .we    (mem_req.tag_we),
    .waddr (mem_req.tag_waddr),
    .wdata (mem_req.tag_wdata),
    .raddr (mem_req.tag_raddr),
    .rdata (mem_rsp.tag_rdata)
  );

  // per-root tag tallies
  tufmg_ram #(
    .WIDTH (tufmg_pkg::FILL_W),
    .DEPTH (tufmg_pkg::MAX_NODES)
  ) u_tally (
    .clk   (clk),
    .we    (mem_req.tally_we),
    .waddr (mem_req.tally_waddr),
    .wdata (mem_req.tally_wdata),
    .raddr (mem_req.tally_raddr),
    .rdata (mem_rsp.tally_rdata)
  );

endmodule

// File: src/tufmg_checker.sv
// port-level checks for the union-find block, bound to the top level
// depends on tufmg_pkg and threshold_union_find_max_group_defines.svh
`timescale 1ns / 1ps
`include "threshold_union_find_max_group_defines.svh"

module tufmg_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tufmg_pkg::CNT_W-1:0] out_count
);

  // a stalled result stays offered
  `TUFMG_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // a stalled result keeps its value
  `TUFMG_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_count))
  // one request at a time: busy right after an accepted request
  `TUFMG_ASSERT_NEXT(a_busy_after_req, clk, rst, in_valid && in_ready, !in_ready)
  // the clearing pass follows reset
  `TUFMG_ASSERT_NEXT_ALWAYS(a_clear_after_rst, clk, rst, !in_ready)

endmodule

bind threshold_union_find_max_group tufmg_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_count (out_ch.largest_group_count)
);
